### src/sms_pkg.sv
// Shared types and constants for the mark-and-sweep slot allocator.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package sms_pkg;

  // table geometry
  localparam int SLOTS  = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 6;

  // action codes of an input word
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_MARK  = 2'd2;
  localparam logic [1:0] ACT_SWEEP = 2'd3;

  // status codes of a result word
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  // commands broadcast to every cell of the chain
  typedef struct packed {
    logic              start;      // seed the scan token into the first cell
    logic              shift;      // move the token one cell along
    logic              clear;      // drop the token everywhere
    logic              claim;      // token cell becomes used
    logic              rel;        // token cell is freed
    logic              begin_col;  // every used cell becomes a candidate
    logic              mark_en;    // clear the mark of one addressed cell
    logic [SLOT_W-1:0] mark_idx;
  } cell_ctl_t;

  // what one cell reports back while it holds the token
  typedef struct packed {
    logic free_hit;   // token here and slot free
    logic sweep_hit;  // token here and slot used and still a candidate
  } cell_stat_t;

endpackage

### src/slot_allocator_mark_sweep.sv
// Top level of the mark-and-sweep slot allocator: cell chain plus scan control.
// Depends on sms_pkg and sms_cell.
`timescale 1ns / 1ps

// Slot allocator with mark-and-sweep collection over a table of SLOTS slots.
// Each slot lives in a cell of a chain; a scan token walks the chain one
// cell per clock while no result word is held up. Begin-collection and
// mark-live words finish in the cycle they are taken. Alloc walks the
// token from slot 0 up to the first free slot, or to the last slot on a
// full table. Sweep always walks the whole chain. Alloc and sweep also
// wait for any cycles in which the previous result word is held by the
// downstream side. Results are registered; a new input word is taken only
// when the block is idle and the result register is empty or is being
// read in that same cycle. No clearing pass is needed after reset.
module slot_allocator_mark_sweep (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] action, [7:2] slot_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] slot_index_res, [7:6] status,
                                 // [13:8] in_use, [15:14] zero
  output logic        m_tuser,   // [0] freed
  output logic        m_tlast    // last result of the input word
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_CLOSE = 2'd3;

  localparam logic [sms_pkg::SLOT_W-1:0] POS_LAST = sms_pkg::SLOT_W'(sms_pkg::SLOTS - 1);

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic [sms_pkg::SLOT_W-1:0] pos;
  logic [sms_pkg::SLOT_W-1:0] pos_next;
  logic [sms_pkg::CNT_W-1:0]  cnt;
  logic [sms_pkg::CNT_W-1:0]  cnt_next;

  logic [1:0]                 in_action;
  logic [sms_pkg::IDX_W-1:0]  in_idx;
  logic                       in_range;

  sms_pkg::cell_ctl_t         ctl;
  sms_pkg::cell_stat_t        stat [sms_pkg::SLOTS];
  logic [sms_pkg::SLOTS:0]    tok_chain;
  logic [sms_pkg::SLOTS-1:0]  free_vec;
  logic [sms_pkg::SLOTS-1:0]  sweep_vec;
  logic                       any_free;
  logic                       any_sweep;

  logic                       out_valid;
  logic                       out_free;
  logic [sms_pkg::IDX_W-1:0]  out_slot;
  logic [1:0]                 out_status;
  logic [sms_pkg::CNT_W-1:0]  out_cnt;
  logic                       out_freed;
  logic                       out_last;

  logic                       emit;
  logic [sms_pkg::IDX_W-1:0]  e_slot;
  logic [1:0]                 e_status;
  logic                       e_freed;
  logic                       e_last;

  assign in_action = s_tdata[1:0];
  assign in_idx    = s_tdata[7:2];
  assign in_range  = ((sms_pkg::IDX_W + 1)'(in_idx) < (sms_pkg::IDX_W + 1)'(sms_pkg::SLOTS));

  // build the chain of slot cells
  assign tok_chain[0] = 1'b0;
  for (genvar i = 0; i < sms_pkg::SLOTS; i++) begin : g_cell
    sms_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .cell_id (sms_pkg::SLOT_W'(i)),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1]),
      .stat    (stat[i])
    );
    assign free_vec[i]  = stat[i].free_hit;
    assign sweep_vec[i] = stat[i].sweep_hit;
  end

  // only the token cell can report a hit
  assign any_free  = |free_vec;
  assign any_sweep = |sweep_vec;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;

  // sequence the scans and form result words
  always_comb begin
    ctl        = '0;
    emit       = 1'b0;
    e_slot     = '0;
    e_status   = sms_pkg::STS_OK;
    e_freed    = 1'b0;
    e_last     = 1'b0;
    state_next = state;
    pos_next   = pos;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          unique case (in_action)
            sms_pkg::ACT_ALLOC: begin
              ctl.start  = 1'b1;
              pos_next   = '0;
              state_next = ST_ALLOC;
            end
            sms_pkg::ACT_BEGIN: begin
              ctl.begin_col = 1'b1;
              emit          = 1'b1;
              e_last        = 1'b1;
            end
            sms_pkg::ACT_MARK: begin
              emit   = 1'b1;
              e_last = 1'b1;
              if (in_range) begin
                ctl.mark_en  = 1'b1;
                ctl.mark_idx = in_idx[sms_pkg::SLOT_W-1:0];
              end else begin
                e_status = sms_pkg::STS_RANGE;
              end
            end
            sms_pkg::ACT_SWEEP: begin
              ctl.start  = 1'b1;
              pos_next   = '0;
              state_next = ST_SWEEP;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        priority if (any_free) begin
          if (out_free) begin
            ctl.claim  = 1'b1;
            ctl.clear  = 1'b1;
            cnt_next   = cnt + 1'b1;
            emit       = 1'b1;
            e_slot     = sms_pkg::IDX_W'(pos);
            e_last     = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (pos == POS_LAST) begin
          if (out_free) begin
            ctl.clear  = 1'b1;
            emit       = 1'b1;
            e_status   = sms_pkg::STS_FULL;
            e_last     = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          ctl.shift = 1'b1;
          pos_next  = pos + 1'b1;
        end
      end
      ST_SWEEP: begin
        if (!any_sweep || out_free) begin
          if (any_sweep) begin
            ctl.rel  = 1'b1;
            cnt_next = cnt - 1'b1;
            emit     = 1'b1;
            e_slot   = sms_pkg::IDX_W'(pos);
            e_freed  = 1'b1;
          end
          if (pos == POS_LAST) begin
            ctl.clear  = 1'b1;
            state_next = ST_CLOSE;
          end else begin
            ctl.shift = 1'b1;
            pos_next  = pos + 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          emit       = 1'b1;
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      cnt   <= cnt_next;
    end
  end

  // hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_slot   <= e_slot;
      out_status <= e_status;
      out_cnt    <= cnt_next;
      out_freed  <= e_freed;
      out_last   <= e_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_cnt, out_status, out_slot};
  assign m_tuser  = out_freed;
  assign m_tlast  = out_last;

endmodule

### src/sms_cell.sv
// One slot of the allocator chain: used bit, candidate mark and scan token.
// Depends on sms_pkg for the command and status structs.
`timescale 1ns / 1ps

module sms_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  sms_pkg::cell_ctl_t         ctl,
  input  logic [sms_pkg::SLOT_W-1:0] cell_id,
  input  logic                       tok_in,
  output logic                       tok_out,
  output sms_pkg::cell_stat_t        stat
);

  logic used;
  logic cand;
  logic token;

  // update the slot bits; token-addressed changes win over broadcasts
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      cand <= 1'b0;
    end else begin
      if (ctl.begin_col) begin
        cand <= used;
      end
      if (ctl.mark_en && (ctl.mark_idx == cell_id)) begin
        cand <= 1'b0;
      end
      if (token && ctl.claim) begin
        used <= 1'b1;
        cand <= 1'b0;
      end
      if (token && ctl.rel) begin
        used <= 1'b0;
        cand <= 1'b0;
      end
    end
  end

  // seed, pass on or drop the scan token
  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
    end else if (ctl.clear) begin
      token <= 1'b0;
    end else if (ctl.start) begin
      token <= (cell_id == '0);
    end else if (ctl.shift) begin
      token <= tok_in;
    end
  end

  assign tok_out        = token;
  assign stat.free_hit  = token && !used;
  assign stat.sweep_hit = token && used && cand;

endmodule

### src/sms_checker.sv
// Port-level checks for the slot allocator, bound to the top level.
// Depends on sms_pkg for the status codes and table size.
`timescale 1ns / 1ps

module sms_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result word changed while stalled");

  // a freed-slot word is never the closing one and always reports ok
  a_freed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tlast && (m_tdata[7:6] == sms_pkg::STS_OK))
    else $error("freed word with last or error status");

  // an error word carries slot zero
  a_err_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[7:6] != sms_pkg::STS_OK) |-> (m_tdata[5:0] == 6'd0))
    else $error("error word with nonzero slot");

  // the used count never passes the table size
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:8] <= 6'(sms_pkg::SLOTS)))
    else $error("used count beyond table size");

endmodule

bind slot_allocator_mark_sweep sms_checker u_sms_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### test/slot_allocator_mark_sweep_checker.sv
// Result checker for the mark-and-sweep slot allocator: watches both stream channels,
// predicts every result word from the accepted input words and compares. Depends on sms_pkg.
`timescale 1ns / 1ps

module slot_allocator_mark_sweep_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] action, [7:2] slot_index
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [5:0] slot_index_res, [7:6] status,
                                 // [13:8] in_use, [15:14] zero
  input  logic        m_tuser,   // [0] freed
  input  logic        m_tlast,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [5:0] slot;
    logic [1:0] status;
    logic [5:0] count;
    logic       freed;
    logic       last;
  } slot_result_t;

  // shadow copy of the slot table
  logic [sms_pkg::SLOTS-1:0] slot_used = '0;
  logic [sms_pkg::SLOTS-1:0] slot_cand = '0;
  logic [5:0]                live_count = '0;

  slot_result_t due_results[$];
  int unsigned  fail_count = 0;

  assign mismatches = fail_count;

  // Update the shadow table for one input word and queue the words it causes.
  task automatic apply_word(input logic [1:0] act, input logic [5:0] idx);
    slot_result_t r;
    bit           found;
    found = 1'b0;
    r = '0;
    case (act)
      sms_pkg::ACT_ALLOC: begin
        r.status = sms_pkg::STS_FULL;
        for (int k = 0; k < sms_pkg::SLOTS; k++) begin
          if (!found && !slot_used[k]) begin
            found = 1'b1;
            slot_used[k] = 1'b1;
            slot_cand[k] = 1'b0;
            live_count = live_count + 6'd1;
            r.slot = 6'(k);
            r.status = sms_pkg::STS_OK;
          end
        end
      end
      sms_pkg::ACT_BEGIN: begin
        slot_cand = slot_cand | slot_used;
      end
      sms_pkg::ACT_MARK: begin
        if (idx >= sms_pkg::SLOTS) r.status = sms_pkg::STS_RANGE;
        else slot_cand[idx] = 1'b0;
      end
      default: begin
        // one word per freed slot, lowest first
        for (int k = 0; k < sms_pkg::SLOTS; k++) begin
          if (slot_used[k] && slot_cand[k]) begin
            slot_used[k] = 1'b0;
            slot_cand[k] = 1'b0;
            live_count = live_count - 6'd1;
            r.slot = 6'(k);
            r.count = live_count;
            r.freed = 1'b1;
            due_results.push_back(r);
          end
        end
        r = '0;
      end
    endcase
    r.count = live_count;
    r.last = 1'b1;
    due_results.push_back(r);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Predict on each accepted input word, compare each accepted result word.
  always @(posedge clk) begin : watch
    slot_result_t want;
    if (rst) begin
      slot_used = '0;
      slot_cand = '0;
      live_count = '0;
      due_results.delete();
    end else begin
      if (s_tvalid && s_tready) apply_word(s_tdata[1:0], s_tdata[7:2]);
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $error("result word with no expectation waiting: data %h user %b last %b",
                 m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("slot_index_res", 16'(want.slot), 16'(m_tdata[5:0]));
          check_field("status", 16'(want.status), 16'(m_tdata[7:6]));
          check_field("in_use", 16'(want.count), 16'(m_tdata[13:8]));
          check_field("pad", 16'd0, 16'(m_tdata[15:14]));
          check_field("freed", 16'(want.freed), 16'(m_tuser));
          check_field("last", 16'(want.last), 16'(m_tlast));
        end
      end
    end
    outstanding = due_results.size();
  end

endmodule

### test/slot_allocator_mark_sweep_tb.sv
// Testbench top for the mark-and-sweep slot allocator: clock, reset, stimulus, verdict.
// Depends on sms_pkg, slot_allocator_mark_sweep and slot_allocator_mark_sweep_checker.
`timescale 1ns / 1ps

module slot_allocator_mark_sweep_tb;

  localparam int unsigned TOTAL_WORDS = 260;
  localparam int unsigned HOLD_AT     = 120;
  localparam int unsigned HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned words_sent = 0;
  bit          src_quiet = 1'b0;
  bit          sink_hold = 1'b0;

  always #4 clk = ~clk;

  slot_allocator_mark_sweep u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  slot_allocator_mark_sweep_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Offer one input word after a random gap and hold it until taken.
  task automatic offer(input logic [1:0] act, input logic [5:0] idx);
    int unsigned gap;
    if (words_sent % 32 == 0) src_quiet = ($urandom_range(0, 3) == 0);
    gap = src_quiet ? 0 : $urandom_range(0, 6);
    repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {idx, act};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic offer_allocs(input int unsigned n);
    repeat (n) offer(sms_pkg::ACT_ALLOC, 6'($urandom_range(0, 63)));
  endtask

  // Stimulus: directed corner cases, then random rounds of mostly well-formed collections.
  initial begin : stimulus
    int unsigned mode;
    int unsigned n;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // empty table: mark of a free slot, sweep and begin with nothing used
    offer(sms_pkg::ACT_MARK, 6'd0);
    offer(sms_pkg::ACT_SWEEP, 6'd0);
    offer(sms_pkg::ACT_BEGIN, 6'd63);
    offer_allocs(4);
    // out-of-range marks and the top free slot
    offer(sms_pkg::ACT_MARK, 6'd32);
    offer(sms_pkg::ACT_MARK, 6'd63);
    offer(sms_pkg::ACT_MARK, 6'd31);
    // collection with one live slot and a fresh slot taken mid-collection
    offer(sms_pkg::ACT_BEGIN, 6'd0);
    offer(sms_pkg::ACT_MARK, 6'd1);
    offer(sms_pkg::ACT_ALLOC, 6'd0);
    offer(sms_pkg::ACT_SWEEP, 6'd0);
    // repeated sweep frees nothing; freed slot comes back unmarked
    offer(sms_pkg::ACT_SWEEP, 6'd0);
    offer(sms_pkg::ACT_ALLOC, 6'd0);
    // begin again without sweep drops the earlier live mark
    offer(sms_pkg::ACT_BEGIN, 6'd0);
    offer(sms_pkg::ACT_MARK, 6'd0);
    offer(sms_pkg::ACT_BEGIN, 6'd0);
    offer(sms_pkg::ACT_SWEEP, 6'd0);
    offer(sms_pkg::ACT_MARK, 6'd42);
    offer(sms_pkg::ACT_MARK, 6'd21);

    // fill past full, then sweep the whole table
    offer_allocs(sms_pkg::SLOTS + 2);
    offer(sms_pkg::ACT_BEGIN, 6'd0);
    offer(sms_pkg::ACT_SWEEP, 6'd0);

    while (words_sent < TOTAL_WORDS) begin
      mode = $urandom_range(0, 9);
      if (mode <= 2) begin
        offer_allocs($urandom_range(1, 36));
      end else if (mode <= 7) begin
        offer(sms_pkg::ACT_BEGIN, 6'($urandom_range(0, 63)));
        n = $urandom_range(0, 12);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0:       offer(sms_pkg::ACT_MARK, 6'($urandom_range(32, 63)));
            1:       offer(sms_pkg::ACT_ALLOC, 6'($urandom_range(0, 63)));
            default: offer(sms_pkg::ACT_MARK, 6'($urandom_range(0, 31)));
          endcase
        end
        if ($urandom_range(0, 9) != 0) offer(sms_pkg::ACT_SWEEP, 6'($urandom_range(0, 63)));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) offer(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)));
      end
    end
    @(negedge clk) s_tvalid <= 1'b0;

    // drain, then allow one full sweep of slack
    n = 0;
    while (outstanding != 0 && n < 100000) begin
      @(negedge clk);
      n++;
    end
    repeat (sms_pkg::SLOTS + 8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random gap per word, quiet stretches, and the long hold-off.
  initial begin : sink
    int unsigned gap;
    int unsigned taken;
    bit          quiet;
    m_tready = 1'b0;
    taken = 0;
    quiet = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (taken % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = quiet ? 0 : $urandom_range(0, 6);
      repeat (gap) @(negedge clk) m_tready <= 1'b0;
      forever begin
        @(negedge clk);
        m_tready <= !sink_hold;
        @(posedge clk);
        if (m_tvalid && m_tready) break;
      end
      taken++;
    end
  end

  // Stall the result side for a long stretch while input words keep coming.
  initial begin : hold_off
    wait (words_sent >= HOLD_AT);
    @(posedge clk) sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold = 1'b0;
  end

  // Give up on a hung run.
  initial begin : watchdog
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
